// File: src/two_body_collision_response_top_defines.svh
// assertion macros for the collision response checker
`ifndef TWO_BODY_COLLISION_RESPONSE_TOP_DEFINES_SVH
`define TWO_BODY_COLLISION_RESPONSE_TOP_DEFINES_SVH

// condition that holds at every edge outside reset
`define TBCR_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("collision response check failed");

// condition that implies a consequence in the next cycle
`define TBCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("collision response check failed");

// state right after a reset edge
`define TBCR_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("collision response reset check failed");

`endif

// File: src/tbcr_pkg.sv
// shared constants, pipeline payload type and helpers for the collision response
package tbcr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int UNIT_BITS  = 15;
    localparam int ELAST_BITS = 15;
    localparam int SQRT_STEPS = 32;
    localparam int QUO_BITS   = 47;
    localparam int DIVA_W     = 50;

    localparam logic [31:0] INF_MASS        = 32'hFFFF_FFFF;
    localparam logic [31:0] THRESHOLD_RESET = 32'd65536000;
    localparam logic [47:0] MOM_CAP         = 48'h7FFF_FFFF_FFFF;
    localparam logic [31:0] POS_SAT         = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_SAT         = 32'h8000_0000;

    // everything an item carries down the pipe; lanes are a_x, a_y, b_x, b_y
    typedef struct packed {
        logic [31:0]       mass_a;
        logic [31:0]       mass_b;
        logic [15:0]       elast_a;
        logic [15:0]       elast_b;
        logic [3:0][31:0]  vel;
        logic [3:0][31:0]  pos;
        logic              coinc;
        logic              below;
        logic              inf_a;
        logic              inf_b;
        logic              dx_neg;
        logic              dy_neg;
        logic [31:0]       adx;
        logic [31:0]       ady;
        logic [3:0][31:0]  vmag;
        logic [3:0][63:0]  vsq;
        logic [1:0][63:0]  dsq;
        logic [3:0][63:0]  mraw;
        logic [3:0][47:0]  mom;
        logic [2:0][63:0]  sq_in;
        logic [2:0][31:0]  sq_root;
        logic [3:0][49:0]  dv_a;
        logic [3:0][31:0]  dv_m;
        logic [3:0][47:0]  dv_q;
        logic [16:0]       ux;
        logic [16:0]       uy;
        logic [3:0][63:0]  dprod;
        logic [1:0][49:0]  dot;
        logic [3:0][67:0]  lprod;
        logic [3:0][49:0]  lpart;
        logic [3:0][51:0]  nmom;
        logic [3:0]        nneg;
        logic [3:0]        nzero;
        logic [3:0][63:0]  vprod;
        logic [3:0][31:0]  nvel;
    } t_pipe;

    // arithmetic shift by the unit scale, rounding toward zero
    function automatic logic signed [67:0] tshr_unit(input logic signed [67:0] s);
        logic [67:0] mag;
        mag = s[67] ? 68'(-s) : 68'(s);
        mag = mag >> UNIT_BITS;
        return s[67] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// File: src/tbcr_sqrt.sv
// pipelined integer square root, one result bit per stage, three lanes
module tbcr_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  tbcr_pkg::t_pipe  i_d,
    output logic             o_ready,
    output logic             o_vld,
    output tbcr_pkg::t_pipe  o_d,
    input  logic             i_ready
);
    localparam int N = tbcr_pkg::SQRT_STEPS;

    logic             r_vld [N];
    tbcr_pkg::t_pipe  r_d   [N];
    logic [2:0][63:0] r_x   [N];
    logic [2:0][63:0] r_res [N];
    logic             w_en  [N];

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic             vld_in;
        tbcr_pkg::t_pipe  d_in;
        logic [2:0][63:0] x_in;
        logic [2:0][63:0] res_in;
        logic [2:0][63:0] n_x;
        logic [2:0][63:0] n_res;

        if (g == 0) begin : g_first
            assign vld_in = i_vld;
            assign d_in   = i_d;
            assign x_in   = i_d.sq_in;
            assign res_in = '0;
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign d_in   = r_d[g-1];
            assign x_in   = r_x[g-1];
            assign res_in = r_res[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_en[g] = !r_vld[g] || i_ready;
        end else begin : g_mid
            assign w_en[g] = !r_vld[g] || w_en[g+1];
        end

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (x_in[l] >= res_in[l] + BIT) begin
                    n_x[l]   = x_in[l] - (res_in[l] + BIT);
                    n_res[l] = (res_in[l] >> 1) + BIT;
                end else begin
                    n_x[l]   = x_in[l];
                    n_res[l] = res_in[l] >> 1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (w_en[g]) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[g]) begin
                r_d[g]   <= d_in;
                r_x[g]   <= n_x;
                r_res[g] <= n_res;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_vld   = r_vld[N-1];

    always_comb begin
        o_d = r_d[N-1];
        for (int l = 0; l < 3; l++) begin
            o_d.sq_root[l] = r_res[N-1][l][31:0];
        end
    end

endmodule

// File: src/tbcr_div.sv
// pipelined restoring divider, floor(a * 2^frac / m) capped at 2^47, four lanes
module tbcr_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  tbcr_pkg::t_pipe  i_d,
    output logic             o_ready,
    output logic             o_vld,
    output tbcr_pkg::t_pipe  o_d,
    input  logic             i_ready
);
    localparam int N  = tbcr_pkg::QUO_BITS;
    localparam int FB = tbcr_pkg::FRAC_BITS;
    localparam int AW = tbcr_pkg::DIVA_W;

    logic             r_vld [N];
    tbcr_pkg::t_pipe  r_d   [N];
    logic [3:0][31:0] r_rem [N];
    logic [3:0][N-1:0] r_q  [N];
    logic [3:0]       r_cap [N];
    logic             w_en  [N];

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam int K = N - 1 - g;
        logic              vld_in;
        tbcr_pkg::t_pipe   d_in;
        logic [3:0][31:0]  rem_in;
        logic [3:0][N-1:0] q_in;
        logic [3:0]        cap_in;
        logic [3:0]        nb;
        logic [3:0][31:0]  n_rem;
        logic [3:0][N-1:0] n_q;

        if (g == 0) begin : g_first
            assign vld_in = i_vld;
            assign d_in   = i_d;
            assign q_in   = '0;
            for (genvar l = 0; l < 4; l++) begin : g_lane
                // top dividend bits are below the divisor unless the quotient caps
                assign rem_in[l] = 32'(i_d.dv_a[l][AW-1:N-FB]);
                assign cap_in[l] = (i_d.dv_m[l] == '0)
                                || (32'(i_d.dv_a[l][AW-1:N-FB]) >= i_d.dv_m[l]);
            end
        end else begin : g_next
            assign vld_in = r_vld[g-1];
            assign d_in   = r_d[g-1];
            assign rem_in = r_rem[g-1];
            assign q_in   = r_q[g-1];
            assign cap_in = r_cap[g-1];
        end

        for (genvar l = 0; l < 4; l++) begin : g_bit
            if (K >= FB) begin : g_num
                assign nb[l] = d_in.dv_a[l][K-FB];
            end else begin : g_zero
                assign nb[l] = 1'b0;
            end
        end

        if (g == N - 1) begin : g_last
            assign w_en[g] = !r_vld[g] || i_ready;
        end else begin : g_mid
            assign w_en[g] = !r_vld[g] || w_en[g+1];
        end

        always_comb begin
            logic [32:0] t;
            for (int l = 0; l < 4; l++) begin
                t = {rem_in[l], nb[l]};
                if (t >= {1'b0, d_in.dv_m[l]}) begin
                    t        = t - {1'b0, d_in.dv_m[l]};
                    n_q[l]   = {q_in[l][N-2:0], 1'b1};
                end else begin
                    n_q[l]   = {q_in[l][N-2:0], 1'b0};
                end
                n_rem[l] = t[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (w_en[g]) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[g]) begin
                r_d[g]   <= d_in;
                r_rem[g] <= n_rem;
                r_q[g]   <= n_q;
                r_cap[g] <= cap_in;
            end
        end
    end

    assign o_ready = w_en[0];
    assign o_vld   = r_vld[N-1];

    always_comb begin
        o_d = r_d[N-1];
        for (int l = 0; l < 4; l++) begin
            o_d.dv_q[l] = r_cap[N-1][l] ? (48'd1 << N) : {1'b0, r_q[N-1][l]};
        end
    end

endmodule

// File: src/two_body_collision_response_top.sv
// two-body 2d collision response: pipelined velocity exchange along the center line
//
//  channel   | handshake                | beat
//  ----------+--------------------------+--------------------------------------
//  input     | i_valid / o_ready        | masses, velocities, positions, elast
//  output    | o_valid / i_ready        | four new velocities, applied, coincident
//  config    | i_cfg_wr_en              | i_cfg_wr_data -> speed threshold
//
// one beat accepted per cycle while the pipe is not held; the stages are: 4 front stages,
// a 32-stage square root, 1 stage, a 47-stage divider for the unit vector, 7 stages, a
// 47-stage divider for the new velocities, 2 stages.
// every stage holds only when it is full and the stage after it is held, so
// bubbles close up and a beat waiting at the output does not block the input.
// synchronous active-low reset empties the pipe and loads the default threshold.
module two_body_collision_response_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_mass_a,
    input  logic signed [31:0] i_vel_a_x,
    input  logic signed [31:0] i_vel_a_y,
    input  logic signed [31:0] i_pos_a_x,
    input  logic signed [31:0] i_pos_a_y,
    input  logic [15:0]        i_elast_a,
    input  logic [31:0]        i_mass_b,
    input  logic signed [31:0] i_vel_b_x,
    input  logic signed [31:0] i_vel_b_y,
    input  logic signed [31:0] i_pos_b_x,
    input  logic signed [31:0] i_pos_b_y,
    input  logic [15:0]        i_elast_b,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_new_vel_a_x,
    output logic signed [31:0] o_new_vel_a_y,
    output logic signed [31:0] o_new_vel_b_x,
    output logic signed [31:0] o_new_vel_b_y,
    output logic               o_applied,
    output logic               o_coincident
);
    localparam int NS = 14;

    logic [31:0]     r_speed_threshold;
    logic            r_v [NS];
    tbcr_pkg::t_pipe r_s [NS];
    logic            n_v [NS];
    tbcr_pkg::t_pipe n_s [NS];
    logic            w_en [NS];

    logic            w_sq_rdy, w_sq_vld;
    tbcr_pkg::t_pipe w_sq;
    logic            w_ud_rdy, w_ud_vld;
    tbcr_pkg::t_pipe w_ud;
    logic            w_vd_rdy, w_vd_vld;
    tbcr_pkg::t_pipe w_vd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_threshold <= tbcr_pkg::THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_speed_threshold <= i_cfg_wr_data;
        end
    end

    // stage enables, back to front
    assign w_en[13] = !r_v[13] || i_ready;
    assign w_en[12] = !r_v[12] || w_en[13];
    assign w_en[11] = !r_v[11] || w_vd_rdy;
    assign w_en[10] = !r_v[10] || w_en[11];
    assign w_en[9]  = !r_v[9]  || w_en[10];
    assign w_en[8]  = !r_v[8]  || w_en[9];
    assign w_en[7]  = !r_v[7]  || w_en[8];
    assign w_en[6]  = !r_v[6]  || w_en[7];
    assign w_en[5]  = !r_v[5]  || w_en[6];
    assign w_en[4]  = !r_v[4]  || w_ud_rdy;
    assign w_en[3]  = !r_v[3]  || w_sq_rdy;
    assign w_en[2]  = !r_v[2]  || w_en[3];
    assign w_en[1]  = !r_v[1]  || w_en[2];
    assign w_en[0]  = !r_v[0]  || w_en[1];

    assign o_ready = w_en[0];

    assign n_v[0]  = i_valid;
    assign n_v[1]  = r_v[0];
    assign n_v[2]  = r_v[1];
    assign n_v[3]  = r_v[2];
    assign n_v[4]  = w_sq_vld;
    assign n_v[5]  = w_ud_vld;
    assign n_v[6]  = r_v[5];
    assign n_v[7]  = r_v[6];
    assign n_v[8]  = r_v[7];
    assign n_v[9]  = r_v[8];
    assign n_v[10] = r_v[9];
    assign n_v[11] = r_v[10];
    assign n_v[12] = w_vd_vld;
    assign n_v[13] = r_v[12];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= n_v[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_en[k]) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    // input capture
    always_comb begin
        n_s[0]         = '0;
        n_s[0].mass_a  = i_mass_a;
        n_s[0].mass_b  = i_mass_b;
        n_s[0].elast_a = i_elast_a;
        n_s[0].elast_b = i_elast_b;
        n_s[0].vel[0]  = i_vel_a_x;
        n_s[0].vel[1]  = i_vel_a_y;
        n_s[0].vel[2]  = i_vel_b_x;
        n_s[0].vel[3]  = i_vel_b_y;
        n_s[0].pos[0]  = i_pos_a_x;
        n_s[0].pos[1]  = i_pos_a_y;
        n_s[0].pos[2]  = i_pos_b_x;
        n_s[0].pos[3]  = i_pos_b_y;
    end

    // center line, magnitudes, flags
    always_comb begin
        logic signed [32:0] dx, dy;
        logic [32:0]        mx, my;
        n_s[1] = r_s[0];
        dx = $signed({r_s[0].pos[2][31], r_s[0].pos[2]})
           - $signed({r_s[0].pos[0][31], r_s[0].pos[0]});
        dy = $signed({r_s[0].pos[3][31], r_s[0].pos[3]})
           - $signed({r_s[0].pos[1][31], r_s[0].pos[1]});
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        if (mx[32] || mx[31] || my[32] || my[31]) begin
            mx = mx >> 1;
            my = my >> 1;
        end
        n_s[1].adx    = mx[31:0];
        n_s[1].ady    = my[31:0];
        n_s[1].dx_neg = dx[32];
        n_s[1].dy_neg = dy[32];
        n_s[1].coinc  = (r_s[0].pos[0] == r_s[0].pos[2]) && (r_s[0].pos[1] == r_s[0].pos[3]);
        n_s[1].inf_a  = (r_s[0].mass_a == tbcr_pkg::INF_MASS);
        n_s[1].inf_b  = (r_s[0].mass_b == tbcr_pkg::INF_MASS);
        for (int l = 0; l < 4; l++) begin
            n_s[1].vmag[l] = r_s[0].vel[l][31] ? 32'(32'd0 - r_s[0].vel[l]) : r_s[0].vel[l];
        end
    end

    // squares and raw momenta
    always_comb begin
        n_s[2]         = r_s[1];
        n_s[2].vsq[0]  = r_s[1].vmag[0] * r_s[1].vmag[0];
        n_s[2].vsq[1]  = r_s[1].vmag[1] * r_s[1].vmag[1];
        n_s[2].vsq[2]  = r_s[1].vmag[2] * r_s[1].vmag[2];
        n_s[2].vsq[3]  = r_s[1].vmag[3] * r_s[1].vmag[3];
        n_s[2].dsq[0]  = r_s[1].adx * r_s[1].adx;
        n_s[2].dsq[1]  = r_s[1].ady * r_s[1].ady;
        n_s[2].mraw[0] = r_s[1].mass_a * r_s[1].vmag[0];
        n_s[2].mraw[1] = r_s[1].mass_a * r_s[1].vmag[1];
        n_s[2].mraw[2] = r_s[1].mass_b * r_s[1].vmag[2];
        n_s[2].mraw[3] = r_s[1].mass_b * r_s[1].vmag[3];
    end

    // radicands and signed, saturated momenta
    always_comb begin
        logic [47:0] pm;
        n_s[3]          = r_s[2];
        n_s[3].sq_in[0] = r_s[2].vsq[0] + r_s[2].vsq[1];
        n_s[3].sq_in[1] = r_s[2].vsq[2] + r_s[2].vsq[3];
        n_s[3].sq_in[2] = r_s[2].dsq[0] + r_s[2].dsq[1];
        for (int l = 0; l < 4; l++) begin
            pm = r_s[2].mraw[l][tbcr_pkg::FRAC_BITS +: 48];
            if (pm > tbcr_pkg::MOM_CAP) begin
                pm = tbcr_pkg::MOM_CAP;
            end
            n_s[3].mom[l] = r_s[2].vel[l][31] ? 48'(48'd0 - pm) : pm;
        end
    end

    tbcr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v[3]),
        .i_d     (r_s[3]),
        .o_ready (w_sq_rdy),
        .o_vld   (w_sq_vld),
        .o_d     (w_sq),
        .i_ready (w_en[4])
    );

    // threshold test and unit vector divide setup
    always_comb begin
        n_s[4]         = w_sq;
        n_s[4].below   = ({1'b0, w_sq.sq_root[0]} + {1'b0, w_sq.sq_root[1]})
                       < {1'b0, r_speed_threshold};
        n_s[4].dv_a    = '0;
        n_s[4].dv_m    = '0;
        n_s[4].dv_a[0] = 50'(w_sq.adx);
        n_s[4].dv_a[1] = 50'(w_sq.ady);
        n_s[4].dv_m[0] = w_sq.sq_root[2];
        n_s[4].dv_m[1] = w_sq.sq_root[2];
    end

    // one extra fraction bit comes out of the divider, dropped here
    tbcr_div u_unit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v[4]),
        .i_d     (r_s[4]),
        .o_ready (w_ud_rdy),
        .o_vld   (w_ud_vld),
        .o_d     (w_ud),
        .i_ready (w_en[5])
    );

    always_comb begin
        logic [15:0] umx, umy;
        n_s[5] = w_ud;
        umx = w_ud.dv_q[0][16:1];
        umy = w_ud.dv_q[1][16:1];
        if (w_ud.sq_root[2] == '0) begin
            umx = '0;
            umy = '0;
        end
        n_s[5].ux = w_ud.dx_neg ? 17'(17'd0 - {1'b0, umx}) : {1'b0, umx};
        n_s[5].uy = w_ud.dy_neg ? 17'(17'd0 - {1'b0, umy}) : {1'b0, umy};
    end

    // projections onto the center line
    always_comb begin
        n_s[6]          = r_s[5];
        n_s[6].dprod[0] = $signed(r_s[5].mom[0]) * $signed(r_s[5].ux);
        n_s[6].dprod[1] = $signed(r_s[5].mom[1]) * $signed(r_s[5].uy);
        n_s[6].dprod[2] = $signed(r_s[5].mom[2]) * $signed(r_s[5].ux);
        n_s[6].dprod[3] = $signed(r_s[5].mom[3]) * $signed(r_s[5].uy);
    end

    always_comb begin
        logic signed [67:0] sa, sb, ta, tb;
        n_s[7] = r_s[6];
        sa = $signed(r_s[6].dprod[0]) + $signed(r_s[6].dprod[1]);
        sb = $signed(r_s[6].dprod[2]) + $signed(r_s[6].dprod[3]);
        ta = tbcr_pkg::tshr_unit(sa);
        tb = tbcr_pkg::tshr_unit(sb);
        n_s[7].dot[0] = ta[49:0];
        n_s[7].dot[1] = tb[49:0];
    end

    always_comb begin
        n_s[8]          = r_s[7];
        n_s[8].lprod[0] = $signed(r_s[7].dot[0]) * $signed(r_s[7].ux);
        n_s[8].lprod[1] = $signed(r_s[7].dot[0]) * $signed(r_s[7].uy);
        n_s[8].lprod[2] = $signed(r_s[7].dot[1]) * $signed(r_s[7].ux);
        n_s[8].lprod[3] = $signed(r_s[7].dot[1]) * $signed(r_s[7].uy);
    end

    always_comb begin
        logic signed [67:0] t;
        n_s[9] = r_s[8];
        for (int l = 0; l < 4; l++) begin
            t = tbcr_pkg::tshr_unit($signed(r_s[8].lprod[l]));
            n_s[9].lpart[l] = t[49:0];
        end
    end

    // swap the along-line parts, reflect against an immovable body, or zero all if both are
    always_comb begin
        logic signed [51:0] p [4];
        logic signed [51:0] lp [4];
        n_s[10] = r_s[9];
        for (int l = 0; l < 4; l++) begin
            p[l]  = $signed(r_s[9].mom[l]);
            lp[l] = $signed(r_s[9].lpart[l]);
        end
        if (r_s[9].inf_a && r_s[9].inf_b) begin
            n_s[10].nmom = '0;
        end else if (r_s[9].inf_a) begin
            n_s[10].nmom[0] = '0;
            n_s[10].nmom[1] = '0;
            n_s[10].nmom[2] = p[2] - lp[2] - lp[2];
            n_s[10].nmom[3] = p[3] - lp[3] - lp[3];
        end else if (r_s[9].inf_b) begin
            n_s[10].nmom[0] = p[0] - lp[0] - lp[0];
            n_s[10].nmom[1] = p[1] - lp[1] - lp[1];
            n_s[10].nmom[2] = '0;
            n_s[10].nmom[3] = '0;
        end else begin
            n_s[10].nmom[0] = p[0] - lp[0] + lp[2];
            n_s[10].nmom[1] = p[1] - lp[1] + lp[3];
            n_s[10].nmom[2] = p[2] - lp[2] + lp[0];
            n_s[10].nmom[3] = p[3] - lp[3] + lp[1];
        end
    end

    always_comb begin
        logic [51:0] mag;
        n_s[11] = r_s[10];
        for (int l = 0; l < 4; l++) begin
            mag = r_s[10].nmom[l][51] ? 52'(52'd0 - r_s[10].nmom[l]) : r_s[10].nmom[l];
            n_s[11].dv_a[l]  = mag[49:0];
            n_s[11].nneg[l]  = r_s[10].nmom[l][51];
            n_s[11].nzero[l] = (r_s[10].nmom[l] == '0);
            n_s[11].dv_m[l]  = (l < 2) ? r_s[10].mass_a : r_s[10].mass_b;
        end
    end

    tbcr_div u_vel_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_v[11]),
        .i_d     (r_s[11]),
        .o_ready (w_vd_rdy),
        .o_vld   (w_vd_vld),
        .o_d     (w_vd),
        .i_ready (w_en[12])
    );

    always_comb begin
        n_s[12]          = w_vd;
        n_s[12].vprod[0] = w_vd.dv_q[0] * w_vd.elast_a;
        n_s[12].vprod[1] = w_vd.dv_q[1] * w_vd.elast_a;
        n_s[12].vprod[2] = w_vd.dv_q[2] * w_vd.elast_b;
        n_s[12].vprod[3] = w_vd.dv_q[3] * w_vd.elast_b;
    end

    // saturate, then pick pass-through, stopped body or response
    always_comb begin
        logic [48:0] v;
        logic [31:0] nv;
        logic        inf;
        n_s[13] = r_s[12];
        for (int l = 0; l < 4; l++) begin
            v   = r_s[12].vprod[l][63:tbcr_pkg::ELAST_BITS];
            inf = (l < 2) ? r_s[12].inf_a : r_s[12].inf_b;
            if (r_s[12].nzero[l]) begin
                nv = '0;
            end else if (!r_s[12].nneg[l]) begin
                nv = (v > 49'(tbcr_pkg::POS_SAT)) ? tbcr_pkg::POS_SAT : v[31:0];
            end else begin
                nv = (v >= 49'(tbcr_pkg::NEG_SAT)) ? tbcr_pkg::NEG_SAT
                                                    : 32'(32'd0 - v[31:0]);
            end
            if (inf) begin
                nv = '0;
            end
            if (r_s[12].coinc || r_s[12].below) begin
                nv = r_s[12].vel[l];
            end
            n_s[13].nvel[l] = nv;
        end
    end

    assign o_valid       = r_v[13];
    assign o_new_vel_a_x = r_s[13].nvel[0];
    assign o_new_vel_a_y = r_s[13].nvel[1];
    assign o_new_vel_b_x = r_s[13].nvel[2];
    assign o_new_vel_b_y = r_s[13].nvel[3];
    assign o_applied     = !(r_s[13].coinc || r_s[13].below);
    assign o_coincident  = r_s[13].coinc;

endmodule

// File: src/tbcr_checker.sv
// port-level checks for the collision response block, bound to the top level
`include "two_body_collision_response_top_defines.svh"

module tbcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        o_ready,
    input logic        i_ready,
    input logic [31:0] o_new_vel_a_x,
    input logic [31:0] o_new_vel_b_y,
    input logic        o_applied,
    input logic        o_coincident
);

    // a response is never applied when the centers coincide
    `TBCR_ASSERT_ALWAYS(a_flags_excl, !(o_valid && o_applied && o_coincident))

    // an empty output stage never holds back the input
    `TBCR_ASSERT_ALWAYS(a_ready_when_empty, o_valid || o_ready)

    `TBCR_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_new_vel_a_x) && $stable(o_new_vel_b_y) && $stable(o_applied))

    `TBCR_ASSERT_RESET(a_reset_empty, !o_valid)

endmodule

bind two_body_collision_response_top tbcr_checker u_tbcr_checker (.*);

// File: sim/tb.sv
// testbench for the two-body collision response pipeline
`timescale 1ns / 100ps

module tb;

    localparam int          TIMEOUT_CYCLES = 400000;
    localparam int          PIPE_LATENCY   = 140;
    localparam logic [63:0] QUOTIENT_CAP   = 64'h0000_8000_0000_0000;
    localparam logic [63:0] MOMENTUM_CAP   = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct {
        logic [31:0]        mass_a;
        logic signed [31:0] vel_a_x;
        logic signed [31:0] vel_a_y;
        logic signed [31:0] pos_a_x;
        logic signed [31:0] pos_a_y;
        logic [15:0]        elast_a;
        logic [31:0]        mass_b;
        logic signed [31:0] vel_b_x;
        logic signed [31:0] vel_b_y;
        logic signed [31:0] pos_b_x;
        logic signed [31:0] pos_b_y;
        logic [15:0]        elast_b;
    } body_pair_t;

    typedef struct {
        logic [31:0] vel_a_x;
        logic [31:0] vel_a_y;
        logic [31:0] vel_b_x;
        logic [31:0] vel_b_y;
        logic        applied;
        logic        coincident;
    } pair_velocities_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [31:0] i_mass_a = '0, i_mass_b = '0;
    logic signed [31:0] i_vel_a_x = '0, i_vel_a_y = '0, i_pos_a_x = '0, i_pos_a_y = '0;
    logic signed [31:0] i_vel_b_x = '0, i_vel_b_y = '0, i_pos_b_x = '0, i_pos_b_y = '0;
    logic [15:0] i_elast_a = '0, i_elast_b = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [31:0] o_new_vel_a_x, o_new_vel_a_y, o_new_vel_b_x, o_new_vel_b_y;
    logic o_applied, o_coincident;

    logic [31:0]      speed_floor;
    pair_velocities_t pending_results[$];
    int               error_count = 0;
    int               cycle_count = 0;
    int               pairs_sent = 0;
    int               results_seen = 0;
    int               applied_seen = 0;
    int               sender_idle_pct = 0;
    int               receiver_stall_pct = 0;

    two_body_collision_response_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_mass_a(i_mass_a), .i_vel_a_x(i_vel_a_x), .i_vel_a_y(i_vel_a_y),
        .i_pos_a_x(i_pos_a_x), .i_pos_a_y(i_pos_a_y), .i_elast_a(i_elast_a),
        .i_mass_b(i_mass_b), .i_vel_b_x(i_vel_b_x), .i_vel_b_y(i_vel_b_y),
        .i_pos_b_x(i_pos_b_x), .i_pos_b_y(i_pos_b_y), .i_elast_b(i_elast_b),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_new_vel_a_x(o_new_vel_a_x), .o_new_vel_a_y(o_new_vel_a_y),
        .o_new_vel_b_x(o_new_vel_b_x), .o_new_vel_b_y(o_new_vel_b_y),
        .o_applied(o_applied), .o_coincident(o_coincident)
    );

    always #2 i_clk = ~i_clk;

    // ---------------- fixed-point predictor ----------------

    function automatic logic [63:0] magnitude(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] res, probe, rest;
        res = 0;
        rest = x;
        probe = 64'h1 << 62;
        while (probe > rest) probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= res + probe) begin
                rest = rest - (res + probe);
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic longint shift_unit(input longint x);
        logic [63:0] r;
        r = magnitude(x) >> tbcr_pkg::UNIT_BITS;
        return (x < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint momentum_of(input logic [31:0] m, input longint v);
        logic [63:0] p;
        p = ({32'b0, m} * magnitude(v)) >> tbcr_pkg::FRAC_BITS;
        if (p > MOMENTUM_CAP) p = MOMENTUM_CAP;
        return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] velocity_from(input longint n, input logic [31:0] m,
                                                  input logic [15:0] e);
        logic [63:0]  a, q, v;
        logic [127:0] quo;
        a = magnitude(n);
        if (a == 0) return 32'h0;
        if (m == 0) begin
            q = QUOTIENT_CAP;
        end else begin
            quo = ({64'b0, a} << tbcr_pkg::FRAC_BITS) / {96'b0, m};
            q = (quo >= {64'b0, QUOTIENT_CAP}) ? QUOTIENT_CAP : quo[63:0];
        end
        v = (q * {48'b0, e}) >> tbcr_pkg::ELAST_BITS;
        if (n >= 0) return (v > 64'h7FFF_FFFF) ? tbcr_pkg::POS_SAT : v[31:0];
        if (v >= 64'h8000_0000) return tbcr_pkg::NEG_SAT;
        return 32'(-v);
    endfunction

    function automatic pair_velocities_t predict_response(input body_pair_t p,
                                                          input logic [31:0] floor_speed);
        pair_velocities_t r;
        logic [63:0] sa, sb, adx, ady, len;
        longint dx, dy, ux, uy, pax, pay, pbx, pby, da, db, alx, aly, blx, bly;
        longint nax, nay, nbx, nby;
        logic inf_a, inf_b;
        sa = root_floor(magnitude(p.vel_a_x) ** 2 + magnitude(p.vel_a_y) ** 2);
        sb = root_floor(magnitude(p.vel_b_x) ** 2 + magnitude(p.vel_b_y) ** 2);
        r.coincident = (p.pos_a_x == p.pos_b_x) && (p.pos_a_y == p.pos_b_y);
        r.applied = 1'b0;
        r.vel_a_x = p.vel_a_x;
        r.vel_a_y = p.vel_a_y;
        r.vel_b_x = p.vel_b_x;
        r.vel_b_y = p.vel_b_y;
        if (r.coincident || (sa + sb) < {32'b0, floor_speed}) return r;

        dx = longint'(p.pos_b_x) - longint'(p.pos_a_x);
        dy = longint'(p.pos_b_y) - longint'(p.pos_a_y);
        adx = magnitude(dx);
        ady = magnitude(dy);
        // keep the square sum inside 64 bits
        if (adx >= 64'h8000_0000 || ady >= 64'h8000_0000) begin
            adx = adx >> 1;
            ady = ady >> 1;
        end
        len = root_floor(adx * adx + ady * ady);
        if (len == 0) begin
            ux = 0;
            uy = 0;
        end else begin
            ux = longint'((adx << tbcr_pkg::UNIT_BITS) / len);
            uy = longint'((ady << tbcr_pkg::UNIT_BITS) / len);
            if (dx < 0) ux = -ux;
            if (dy < 0) uy = -uy;
        end

        inf_a = (p.mass_a == tbcr_pkg::INF_MASS);
        inf_b = (p.mass_b == tbcr_pkg::INF_MASS);
        pax = momentum_of(p.mass_a, p.vel_a_x);
        pay = momentum_of(p.mass_a, p.vel_a_y);
        pbx = momentum_of(p.mass_b, p.vel_b_x);
        pby = momentum_of(p.mass_b, p.vel_b_y);
        da = shift_unit(pax * ux + pay * uy);
        db = shift_unit(pbx * ux + pby * uy);
        alx = shift_unit(da * ux);
        aly = shift_unit(da * uy);
        blx = shift_unit(db * ux);
        bly = shift_unit(db * uy);

        if (inf_a && inf_b) begin
            nax = 0; nay = 0; nbx = 0; nby = 0;
        end else if (inf_a) begin
            nax = 0; nay = 0;
            nbx = pbx - 2 * blx;
            nby = pby - 2 * bly;
        end else if (inf_b) begin
            nbx = 0; nby = 0;
            nax = pax - 2 * alx;
            nay = pay - 2 * aly;
        end else begin
            nax = pax - alx + blx;
            nay = pay - aly + bly;
            nbx = pbx - blx + alx;
            nby = pby - bly + aly;
        end
        r.vel_a_x = inf_a ? 32'h0 : velocity_from(nax, p.mass_a, p.elast_a);
        r.vel_a_y = inf_a ? 32'h0 : velocity_from(nay, p.mass_a, p.elast_a);
        r.vel_b_x = inf_b ? 32'h0 : velocity_from(nbx, p.mass_b, p.elast_b);
        r.vel_b_y = inf_b ? 32'h0 : velocity_from(nby, p.mass_b, p.elast_b);
        r.applied = 1'b1;
        return r;
    endfunction

    // ---------------- monitors ----------------

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("%0t timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("tb: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        body_pair_t       beat;
        pair_velocities_t want;
        if (i_rst_n && i_valid && o_ready) begin
            beat.mass_a = i_mass_a;   beat.mass_b = i_mass_b;
            beat.vel_a_x = i_vel_a_x; beat.vel_a_y = i_vel_a_y;
            beat.vel_b_x = i_vel_b_x; beat.vel_b_y = i_vel_b_y;
            beat.pos_a_x = i_pos_a_x; beat.pos_a_y = i_pos_a_y;
            beat.pos_b_x = i_pos_b_x; beat.pos_b_y = i_pos_b_y;
            beat.elast_a = i_elast_a; beat.elast_b = i_elast_b;
            pending_results.push_back(predict_response(beat, speed_floor));
        end
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t result beat with nothing expected: actual %h %h %h %h",
                         $time, o_new_vel_a_x, o_new_vel_a_y, o_new_vel_b_x,
                         o_new_vel_b_y);
            end else begin
                want = pending_results.pop_front();
                if (o_applied) applied_seen++;
                compare_field("new_vel_a_x", want.vel_a_x, o_new_vel_a_x);
                compare_field("new_vel_a_y", want.vel_a_y, o_new_vel_a_y);
                compare_field("new_vel_b_x", want.vel_b_x, o_new_vel_b_x);
                compare_field("new_vel_b_y", want.vel_b_y, o_new_vel_b_y);
                compare_field("applied", 32'(want.applied), 32'(o_applied));
                compare_field("coincident", 32'(want.coincident), 32'(o_coincident));
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_pair(input body_pair_t p);
        int gap;
        gap = 0;
        if (sender_idle_pct > 0)
            while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mass_a <= p.mass_a;   i_mass_b <= p.mass_b;
        i_vel_a_x <= p.vel_a_x; i_vel_a_y <= p.vel_a_y;
        i_vel_b_x <= p.vel_b_x; i_vel_b_y <= p.vel_b_y;
        i_pos_a_x <= p.pos_a_x; i_pos_a_y <= p.pos_a_y;
        i_pos_b_x <= p.pos_b_x; i_pos_b_y <= p.pos_b_y;
        i_elast_a <= p.elast_a; i_elast_b <= p.elast_b;
        do @(posedge i_clk); while (!o_ready);
        pairs_sent++;
    endtask

    // the last accepted beat is queued by the monitor at the same edge
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_threshold(input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        speed_floor = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick_mass();
        case ($urandom_range(9))
            0: return tbcr_pkg::INF_MASS;
            1: return 32'h0;
            2: return $urandom();
            3: return $urandom_range(255);
            default: return $urandom_range(32'h0064_0000, 32'h0000_4000);
        endcase
    endfunction

    function automatic logic [31:0] pick_velocity();
        case ($urandom_range(5))
            0: return $urandom();
            1: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
            2: return 32'($signed($urandom_range(2047))) <<< 16;
            default: return $urandom_range(32'h1000_0000) - 32'h0800_0000;
        endcase
    endfunction

    function automatic body_pair_t random_pair();
        body_pair_t p;
        p.mass_a = pick_mass();
        p.mass_b = pick_mass();
        p.vel_a_x = pick_velocity(); p.vel_a_y = pick_velocity();
        p.vel_b_x = pick_velocity(); p.vel_b_y = pick_velocity();
        p.pos_a_x = $urandom(); p.pos_a_y = $urandom();
        if ($urandom_range(3) == 0) begin
            p.pos_b_x = $urandom(); p.pos_b_y = $urandom();
        end else begin
            // neighbors a few units apart, as a broad phase would hand over
            p.pos_b_x = p.pos_a_x + $urandom_range(32'h0008_0000) - 32'h0004_0000;
            p.pos_b_y = p.pos_a_y + $urandom_range(32'h0008_0000) - 32'h0004_0000;
        end
        if ($urandom_range(24) == 0) begin
            p.pos_b_x = p.pos_a_x;
            p.pos_b_y = p.pos_a_y;
        end
        p.elast_a = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768));
        p.elast_b = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(32768));
        return p;
    endfunction

    function automatic body_pair_t head_on(input logic [31:0] ma, input logic [31:0] mb);
        body_pair_t p;
        p.mass_a = ma; p.mass_b = mb;
        p.vel_a_x = 32'h0400_0000; p.vel_a_y = 32'h0010_0000;
        p.vel_b_x = -32'sh0300_0000; p.vel_b_y = 32'h0;
        p.pos_a_x = 32'h0; p.pos_a_y = 32'h0;
        p.pos_b_x = 32'h0003_0000; p.pos_b_y = 32'h0001_0000;
        p.elast_a = 16'h8000; p.elast_b = 16'h6000;
        return p;
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        body_pair_t p;
        write_threshold(tbcr_pkg::THRESHOLD_RESET);
        send_pair(head_on(32'h0001_0000, 32'h0002_0000));
        send_pair(head_on(tbcr_pkg::INF_MASS, 32'h0002_0000));
        send_pair(head_on(32'h0001_0000, tbcr_pkg::INF_MASS));
        send_pair(head_on(tbcr_pkg::INF_MASS, tbcr_pkg::INF_MASS));
        send_pair(head_on(32'h0, 32'h0003_0000));
        send_pair(head_on(32'h0, 32'h0));
        send_pair(head_on(32'h0000_0001, 32'hFFFF_FFFE));
        p = head_on(32'h0001_0000, 32'h0001_0000);
        p.elast_a = 16'h0; p.elast_b = 16'hFFFF;
        send_pair(p);
        p.mass_a = 32'h0; p.elast_a = 16'h0;
        send_pair(p);
        // centers on top of each other, fast and slow
        p = head_on(32'h0001_0000, 32'h0001_0000);
        p.pos_b_x = p.pos_a_x; p.pos_b_y = p.pos_a_y;
        send_pair(p);
        p.vel_a_x = 32'h0; p.vel_b_x = 32'h0; p.vel_a_y = 32'h1;
        send_pair(p);
        // slow pair stays below the threshold
        p = head_on(32'h0001_0000, 32'h0001_0000);
        p.vel_a_x = 32'h0100_0000; p.vel_b_x = 32'h0;
        send_pair(p);
        // extreme velocities and positions
        p = head_on(32'hFFFF_FFFE, 32'hFFFF_FFFE);
        p.vel_a_x = 32'h8000_0000; p.vel_a_y = 32'h7FFF_FFFF;
        p.vel_b_x = 32'h7FFF_FFFF; p.vel_b_y = 32'h8000_0000;
        p.pos_a_x = 32'h8000_0000; p.pos_b_x = 32'h7FFF_FFFF;
        p.pos_a_y = 32'h7FFF_FFFF; p.pos_b_y = 32'h8000_0000;
        p.elast_a = 16'hFFFF; p.elast_b = 16'hFFFF;
        send_pair(p);
        p.pos_a_y = 32'h0; p.pos_b_y = 32'h0;
        send_pair(p);
        p.pos_b_x = 32'h8000_0001; p.mass_a = 32'h0;
        send_pair(p);
        p = head_on(32'h0000_0100, 32'h0000_0100);
        p.pos_b_x = 32'h0000_0001; p.pos_b_y = 32'h0;
        send_pair(p);
        p.pos_b_x = 32'hFFFF_FFFF; p.pos_b_y = 32'hFFFF_FFFF;
        send_pair(p);
        wait_idle();
        write_threshold(32'h0);
        p = head_on(32'h0001_0000, 32'h0001_0000);
        p.vel_a_x = 32'h0; p.vel_a_y = 32'h0; p.vel_b_x = 32'h0; p.vel_b_y = 32'h0;
        send_pair(p);
        p.vel_a_x = 32'h1;
        send_pair(p);
        wait_idle();
        write_threshold(32'hFFFF_FFFF);
        send_pair(head_on(32'h0001_0000, 32'h0002_0000));
        p = head_on(32'h0001_0000, 32'h0002_0000);
        p.vel_a_x = 32'h8000_0000; p.vel_a_y = 32'h8000_0000;
        p.vel_b_x = 32'h8000_0000; p.vel_b_y = 32'h8000_0000;
        send_pair(p);
        wait_idle();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct,
                                     input int stall_pct, input logic [31:0] threshold);
        write_threshold(threshold);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            send_pair(random_pair());
            // let the pipe run dry once mid-phase
            if (n == count / 2) wait_idle();
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        speed_floor = tbcr_pkg::THRESHOLD_RESET;
        @(posedge i_clk);
        test_directed();
        test_random_phase(200, 0, 0, tbcr_pkg::THRESHOLD_RESET);
        test_random_phase(200, 64, 0, 32'h0000_0000);
        test_random_phase(200, 0, 64, $urandom_range(32'h2000_0000));
        test_random_phase(160, 6, 6, 32'h0010_0000);
        test_random_phase(40, 6, 6, 32'hFFFF_FFFF);
        repeat (PIPE_LATENCY + 20) @(posedge i_clk);
        $display("covered %0d pairs, %0d results, %0d with the response applied",
                 pairs_sent, results_seen, applied_seen);
        $display("thresholds from zero to all ones, with sender gaps and receiver stalls");
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
